>>> sv/nps_pkg.sv
package nps_pkg;

  localparam int PRIMARY_DEPTH = 4096;
  localparam int BAND_DEPTH    = 4096;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int DIST_W  = 52;
  localparam int OIDX_W  = 12;
  localparam int POINT_W = 3 * COORD_W;

  localparam int PRI_AW = (PRIMARY_DEPTH > 1) ? $clog2(PRIMARY_DEPTH) : 1;
  localparam int BND_AW = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;
  localparam int IDX_W  = (PRI_AW > BND_AW) ? PRI_AW : BND_AW;

  localparam int PRI_CW = $clog2(PRIMARY_DEPTH + 1);
  localparam int BND_CW = $clog2(BAND_DEPTH + 1);
  localparam int CNT_W  = (PRI_CW > BND_CW) ? PRI_CW : BND_CW;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [1:0] MODE_LOAD_PRI  = 2'd0;
  localparam logic [1:0] MODE_LOAD_BAND = 2'd1;
  localparam logic [1:0] MODE_QUERY     = 2'd2;

  localparam logic REG_BAND_LOW  = 1'b0;
  localparam logic REG_BAND_HIGH = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [SUM_W-1:0]  sum_sq;
  } cand_t;

endpackage

>>> sv/nps_in_if.sv
interface nps_in_if
  import nps_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;

  modport source (output valid, mode, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, mode, coord_x, coord_y, coord_z, output ready);
endinterface

>>> sv/nps_out_if.sv
interface nps_out_if
  import nps_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              found;
  logic              from_band_set;
  logic [OIDX_W-1:0] nearest_index;
  logic [DIST_W-1:0] nearest_dist_sq;

  modport source (output valid, found, from_band_set, nearest_index, nearest_dist_sq,
                  input ready);
  modport sink (input valid, found, from_band_set, nearest_index, nearest_dist_sq,
                output ready);
endinterface

>>> sv/nearest_point_search_two_sets.sv
// Nearest point search over two stored point sets.
// in_i carries one beat per item: mode selects a load into the primary set,
// a load into the banded set, or a query; coordinates are signed 24-bit
// fixed point with 16 fractional bits. A load gives no result; a load into a
// full set and the unused mode are dropped. A query whose y lies strictly
// between the band registers scans the banded set, else the primary set.
// out_o gets one beat per query: found, the set searched, the index of the
// nearest point (earliest on ties) and the squared distance. A scan does one
// RAM read per cycle at the scan address, each feeding a three-stage
// difference/square/sum pipe and a compare; an empty set reads nothing.
// in_i takes no item while a scan runs; loads are taken while a result
// waits in the output register. A finished scan holds while the receiver
// stalls with a result pending. Band registers sit on the APB port at byte
// 0 (low) and 4 (high). Reset empties both sets, zeroes the band limits and
// drops any result; point memories are not cleared, as only loaded entries
// are read.
module nearest_point_search_two_sets
  import nps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  nps_in_if.sink            in_i,
  nps_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                      state_q, state_d;
  logic signed [COORD_W-1:0] band_lo_q, band_hi_q;
  logic [PRI_CW-1:0]         pri_cnt_q;
  logic [BND_CW-1:0]         bnd_cnt_q;
  logic [CNT_W-1:0]          cnt_q, issue_q, ret_q;
  logic                      set_q;
  point_t                    qry_q;
  logic                      rd_vld_q;
  logic [IDX_W-1:0]          rd_idx_q;
  logic                      have_q;
  logic [IDX_W-1:0]          best_idx_q;
  logic [SUM_W-1:0]          best_dist_q;
  logic                      out_vld_q;
  logic                      out_found_q, out_band_q;
  logic [OIDX_W-1:0]         out_idx_q;
  logic [DIST_W-1:0]         out_dist_q;

  logic   in_fire, cfg_wr, issue, scan_done, out_load, in_band;
  logic   pri_we, bnd_we;
  point_t in_pt, pri_rd, bnd_rd, rd_pt;
  cand_t  cand;

  assign in_pt.x = in_i.coord_x;
  assign in_pt.y = in_i.coord_y;
  assign in_pt.z = in_i.coord_z;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (paddr[2] == REG_BAND_HIGH) ? APB_DW'($unsigned(band_hi_q))
                                               : APB_DW'($unsigned(band_lo_q));

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_band    = (band_lo_q < in_i.coord_y) && (in_i.coord_y < band_hi_q);

  assign pri_we = in_fire && (in_i.mode == MODE_LOAD_PRI)
                  && (pri_cnt_q < PRI_CW'(PRIMARY_DEPTH));
  assign bnd_we = in_fire && (in_i.mode == MODE_LOAD_BAND)
                  && (bnd_cnt_q < BND_CW'(BAND_DEPTH));

  assign issue     = (state_q == ST_SCAN) && (issue_q < cnt_q);
  assign scan_done = (state_q == ST_SCAN) && (ret_q == cnt_q);
  assign out_load  = scan_done && (!out_vld_q || out_o.ready);

  nps_ram #(.WIDTH(POINT_W), .DEPTH(PRIMARY_DEPTH)) u_pri_ram (
    .clk_i   (clk_i),
    .we_i    (pri_we),
    .waddr_i (pri_cnt_q[PRI_AW-1:0]),
    .wdata_i (in_pt),
    .raddr_i (issue_q[PRI_AW-1:0]),
    .rdata_o (pri_rd)
  );

  nps_ram #(.WIDTH(POINT_W), .DEPTH(BAND_DEPTH)) u_bnd_ram (
    .clk_i   (clk_i),
    .we_i    (bnd_we),
    .waddr_i (bnd_cnt_q[BND_AW-1:0]),
    .wdata_i (in_pt),
    .raddr_i (issue_q[BND_AW-1:0]),
    .rdata_o (bnd_rd)
  );

  assign rd_pt = set_q ? bnd_rd : pri_rd;

  nps_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .idx_i  (rd_idx_q),
    .pt_i   (rd_pt),
    .qry_i  (qry_q),
    .cand_o (cand)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.mode == MODE_QUERY)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      band_lo_q <= '0;
      band_hi_q <= '0;
      pri_cnt_q <= '0;
      bnd_cnt_q <= '0;
      issue_q   <= '0;
      ret_q     <= '0;
      rd_vld_q  <= 1'b0;
      have_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (cfg_wr) begin
        case (paddr[2])
          REG_BAND_LOW:  band_lo_q <= pwdata[COORD_W-1:0];
          REG_BAND_HIGH: band_hi_q <= pwdata[COORD_W-1:0];
          default: ;
        endcase
      end
      if (pri_we) begin
        pri_cnt_q <= pri_cnt_q + 1'b1;
      end
      if (bnd_we) begin
        bnd_cnt_q <= bnd_cnt_q + 1'b1;
      end
      if (in_fire && (in_i.mode == MODE_QUERY)) begin
        issue_q <= '0;
        ret_q   <= '0;
        have_q  <= 1'b0;
      end else begin
        if (issue) begin
          issue_q <= issue_q + 1'b1;
        end
        if (cand.valid) begin
          ret_q <= ret_q + 1'b1;
          if (!have_q || (cand.sum_sq < best_dist_q)) begin
            have_q <= 1'b1;
          end
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= issue_q[IDX_W-1:0];
    if (in_fire && (in_i.mode == MODE_QUERY)) begin
      qry_q <= in_pt;
      set_q <= in_band;
      cnt_q <= in_band ? CNT_W'(bnd_cnt_q) : CNT_W'(pri_cnt_q);
    end
    // strict compare keeps the earlier point on equal distance
    if (cand.valid && (!have_q || (cand.sum_sq < best_dist_q))) begin
      best_idx_q  <= cand.idx;
      best_dist_q <= cand.sum_sq;
    end
    if (out_load) begin
      out_found_q <= have_q;
      out_band_q  <= set_q;
      out_idx_q   <= have_q ? OIDX_W'(best_idx_q) : '0;
      out_dist_q  <= have_q ? DIST_W'(best_dist_q) : '0;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.found           = out_found_q;
  assign out_o.from_band_set   = out_band_q;
  assign out_o.nearest_index   = out_idx_q;
  assign out_o.nearest_dist_sq = out_dist_q;

endmodule

>>> sv/nps_ram.sv
module nps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> sv/nps_dist.sv
module nps_dist
  import nps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [IDX_W-1:0] idx_i,
  input  point_t           pt_i,
  input  point_t           qry_i,
  output cand_t            cand_o
);

  logic                     s1_vld_q, s2_vld_q, s3_vld_q;
  logic [IDX_W-1:0]         s1_idx_q, s2_idx_q, s3_idx_q;
  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic [SQ_W-1:0]          sx_q, sy_q, sz_q;
  logic [SUM_W-1:0]         sum_q;

  logic signed [2*DIFF_W-1:0] px, py, pz;

  always_comb begin
    px = dx_q * dx_q;
    py = dy_q * dy_q;
    pz = dz_q * dz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= idx_i;
    dx_q     <= DIFF_W'(pt_i.x) - DIFF_W'(qry_i.x);
    dy_q     <= DIFF_W'(pt_i.y) - DIFF_W'(qry_i.y);
    dz_q     <= DIFF_W'(pt_i.z) - DIFF_W'(qry_i.z);
    s2_idx_q <= s1_idx_q;
    // each square stays below 2^48, so the sign bits carry nothing
    sx_q     <= px[SQ_W-1:0];
    sy_q     <= py[SQ_W-1:0];
    sz_q     <= pz[SQ_W-1:0];
    s3_idx_q <= s2_idx_q;
    sum_q    <= SUM_W'(sx_q) + SUM_W'(sy_q) + SUM_W'(sz_q);
  end

  assign cand_o.valid  = s3_vld_q;
  assign cand_o.idx    = s3_idx_q;
  assign cand_o.sum_sq = sum_q;

endmodule

>>> tb/nearest_point_search_two_sets_test.sv
module nearest_point_search_two_sets_test;
  import nps_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    logic              found;
    logic              from_band;
    logic [OIDX_W-1:0] index;
    logic [DIST_W-1:0] dist_sq;
  } nearest_t;

  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam coord_t     COORD_MIN     = coord_t'(24'h800000);
  localparam coord_t     COORD_MAX     = coord_t'(24'h7FFFFF);
  localparam int         SETTLE_CYCLES = 8;
  localparam int         QUIET_LIMIT   = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  nps_in_if  in_if ();
  nps_out_if out_if ();

  nearest_point_search_two_sets DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the block: stored sets, band limits, results still owed
  point_t   primary_pts[$];
  point_t   band_pts[$];
  coord_t   band_low;
  coord_t   band_high;
  nearest_t pending_nearest[$];

  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold;
  int fail_count;
  int in_beats;
  int queries_sent;
  int results_checked;
  int reg_writes;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("Mismatch at result %0d, %s: got %0h, expected %0h", results_checked, what,
             got, want);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic coord_t rand_coord();
    return coord_t'($urandom());
  endfunction

  function automatic coord_t nudge(input coord_t c);
    return c + coord_t'($urandom_range(0, 64)) - coord_t'(32);
  endfunction

  function automatic nearest_t nearest_in(ref point_t pts[$], input point_t q);
    nearest_t r;
    longint   dx, dy, dz, d, best;
    r.found     = 1'b0;
    r.from_band = 1'b0;
    r.index     = '0;
    best        = 0;
    foreach (pts[i]) begin
      dx = longint'(pts[i].x) - longint'(q.x);
      dy = longint'(pts[i].y) - longint'(q.y);
      dz = longint'(pts[i].z) - longint'(q.z);
      d  = dx * dx + dy * dy + dz * dz;
      // strict compare keeps the earlier point on a tie
      if (!r.found || d < best) begin
        r.found = 1'b1;
        best    = d;
        r.index = OIDX_W'(i);
      end
    end
    r.dist_sq = DIST_W'(best);
    return r;
  endfunction

  function automatic void track_beat(input logic [1:0] mode, input point_t p);
    nearest_t r;
    logic     in_band;
    case (mode)
      MODE_LOAD_PRI: begin
        if (primary_pts.size() < PRIMARY_DEPTH) primary_pts = {primary_pts, p};
      end
      MODE_LOAD_BAND: begin
        if (band_pts.size() < BAND_DEPTH) band_pts = {band_pts, p};
      end
      MODE_QUERY: begin
        in_band = (band_low < p.y) && (p.y < band_high);
        if (in_band) r = nearest_in(band_pts, p);
        else r = nearest_in(primary_pts, p);
        r.from_band = in_band;
        pending_nearest = {pending_nearest, r};
        queries_sent++;
      end
      default: ;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_point(input logic [1:0] mode, input coord_t x, input coord_t y,
                            input coord_t z);
    int     gap;
    point_t p;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    p.x = x;
    p.y = y;
    p.z = z;
    in_if.valid   <= 1'b1;
    in_if.mode    <= mode;
    in_if.coord_x <= x;
    in_if.coord_y <= y;
    in_if.coord_z <= z;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    track_beat(mode, p);
    in_beats++;
    @(negedge clk_i);
  endtask

  task automatic wait_results();
    in_if.valid <= 1'b0;
    while (pending_nearest.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // write, then read back over the same select
  task automatic write_band(input logic which, input coord_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[COORD_W-1:0] !== value)
      report_mismatch("band register readback", prdata, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (which == REG_BAND_LOW) band_low = value;
    else band_high = value;
    reg_writes++;
  endtask

  task automatic set_band(input coord_t lo, input coord_t hi);
    write_band(REG_BAND_LOW, lo);
    write_band(REG_BAND_HIGH, hi);
  endtask

  task automatic test_empty_sets();
    send_point(MODE_QUERY, '0, '0, '0);
    send_point(MODE_QUERY, COORD_MIN, COORD_MAX, COORD_MIN);
    wait_results();
    set_band(coord_t'(-16), coord_t'(16));
    send_point(MODE_QUERY, COORD_MAX, '0, COORD_MAX);
    wait_results();
  endtask

  task automatic test_directed_points();
    // a lone far point gives the widest distance
    send_point(MODE_LOAD_PRI, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(MODE_QUERY, COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(MODE_LOAD_PRI, COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(MODE_LOAD_PRI, '0, '0, '0);
    send_point(MODE_LOAD_PRI, coord_t'(1000), coord_t'(500000), '0);
    send_point(MODE_LOAD_PRI, coord_t'(-1000), coord_t'(500000), '0);
    send_point(MODE_LOAD_PRI, coord_t'(-1000), coord_t'(500000), '0);
    send_point(MODE_LOAD_BAND, coord_t'(5), coord_t'(5), coord_t'(5));
    send_point(MODE_LOAD_BAND, coord_t'(-5), coord_t'(-5), coord_t'(-5));
    send_point(MODE_LOAD_BAND, COORD_MAX, '0, COORD_MIN);
    send_point(MODE_UNUSED, COORD_MAX, '0, COORD_MAX);
    send_point(MODE_QUERY, COORD_MAX, '0, COORD_MAX);
    send_point(MODE_QUERY, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(MODE_QUERY, COORD_MIN, COORD_MIN, COORD_MIN);
    // equidistant pair, then an exact duplicate
    send_point(MODE_QUERY, '0, coord_t'(500000), '0);
    send_point(MODE_QUERY, coord_t'(-1000), coord_t'(500000), '0);
    // band edges are exclusive
    send_point(MODE_QUERY, coord_t'(3), coord_t'(-16), coord_t'(3));
    send_point(MODE_QUERY, coord_t'(3), coord_t'(-15), coord_t'(3));
    send_point(MODE_QUERY, coord_t'(3), coord_t'(15), coord_t'(3));
    send_point(MODE_QUERY, coord_t'(3), coord_t'(16), coord_t'(3));
    send_point(MODE_QUERY, COORD_MIN, coord_t'(1), COORD_MAX);
    wait_results();
  endtask

  task automatic test_band_settings();
    coord_t lo_list[5];
    coord_t hi_list[5];
    coord_t y;
    lo_list = '{COORD_MIN, coord_t'(100), coord_t'(7), COORD_MAX, coord_t'(-40000)};
    hi_list = '{COORD_MAX, coord_t'(-100), coord_t'(7), COORD_MIN, coord_t'(40000)};
    for (int s = 0; s < 5; s++) begin
      set_band(lo_list[s], hi_list[s]);
      for (int k = 0; k < 6; k++) begin
        case (k)
          0: y = lo_list[s];
          1: y = lo_list[s] + coord_t'(1);
          2: y = hi_list[s] - coord_t'(1);
          3: y = hi_list[s];
          default: y = rand_coord();
        endcase
        send_point(MODE_QUERY, rand_coord(), y, rand_coord());
      end
      wait_results();
    end
  endtask

  task automatic test_random_mix();
    int     r;
    point_t base;
    set_band(coord_t'(-1048576), coord_t'(1048576));
    for (int i = 0; i < 70; i++) begin
      // a stretch with no idling on either side
      tx_idle_on = !(i >= 30 && i < 50);
      rx_idle_on = tx_idle_on;
      r = $urandom_range(0, 99);
      if (r < 30) begin
        if (primary_pts.size() > 0 && $urandom_range(0, 6) == 0)
          base = primary_pts[$urandom_range(0, primary_pts.size() - 1)];
        else base = {rand_coord(), rand_coord(), rand_coord()};
        send_point(MODE_LOAD_PRI, base.x, base.y, base.z);
      end else if (r < 50) begin
        send_point(MODE_LOAD_BAND, rand_coord(),
                   coord_t'($urandom_range(0, 2097150)) - coord_t'(1048575), rand_coord());
      end else if (r < 95) begin
        if ($urandom_range(0, 1) && band_pts.size() > 0)
          base = band_pts[$urandom_range(0, band_pts.size() - 1)];
        else if ($urandom_range(0, 2) != 0 && primary_pts.size() > 0)
          base = primary_pts[$urandom_range(0, primary_pts.size() - 1)];
        else base = {rand_coord(), rand_coord(), rand_coord()};
        send_point(MODE_QUERY, nudge(base.x), nudge(base.y), nudge(base.z));
      end else begin
        send_point(MODE_UNUSED, rand_coord(), rand_coord(), rand_coord());
      end
    end
    wait_results();
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold    = 300;
    // result sits in the output register, loads pass, the next query stalls input
    for (int i = 0; i < 12; i++)
      send_point((i % 3 == 0) ? MODE_QUERY : MODE_LOAD_PRI, rand_coord(),
                 rand_coord(), rand_coord());
    wait_results();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int i = 0; i < 8; i++)
      send_point((i % 2 == 0) ? MODE_QUERY : MODE_LOAD_BAND, rand_coord(),
                 coord_t'($urandom_range(0, 2000)) - coord_t'(1000), rand_coord());
    wait_results();
  endtask

  // result receiver: long hold-off first, then random stalls
  initial begin
    int stall;
    stall        = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 3) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    nearest_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_nearest.size() == 0) begin
        report_mismatch("result beat with no query pending", 1, 0);
      end else begin
        want = pending_nearest.pop_front();
        check_field("found", out_if.found, want.found);
        check_field("from_band_set", out_if.from_band_set, want.from_band);
        check_field("nearest_index", out_if.nearest_index, want.index);
        check_field("nearest_dist_sq", out_if.nearest_dist_sq, want.dist_sq);
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin : watchdog
    int quiet_cycles;
    if (!rst_ni || psel === 1'b1 || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
        (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d results outstanding", quiet_cycles,
                 pending_nearest.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.mode    = MODE_LOAD_PRI;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.coord_z = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    band_low      = '0;
    band_high     = '0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    rx_hold       = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_sets();
    test_directed_points();
    test_band_settings();
    test_random_mix();
    test_backpressure();
    wait_results();
    $display("Covered %0d input beats and %0d checked results over %0d band register writes",
             in_beats, results_checked, reg_writes);
    $display("Included empty sets, ties, band edges, crossed limits and receiver stalls");
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
sv/nps_pkg.sv
sv/nps_in_if.sv
sv/nps_out_if.sv
sv/nps_ram.sv
sv/nps_dist.sv
sv/nearest_point_search_two_sets.sv
tb/nearest_point_search_two_sets_test.sv
